[rtl/core/mtfids_pkg.sv]
// Shared types and command codes for the move-to-front identifier stack.
`timescale 1ns / 1ps

package mtfids_pkg;

    localparam int unsigned FIELD_IDENT_W = 16;

    localparam logic [1:0] CMD_OPEN   = 2'd0;
    localparam logic [1:0] CMD_SWITCH = 2'd1;
    localparam logic [1:0] CMD_CLOSE  = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic [FIELD_IDENT_W-1:0] ident;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_IDENT_W-1:0] top_ident;
        logic                     top_valid;
        logic                     matched;
        logic                     full_drop;
    } t_out_beat;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_SWITCH,
        OP_PULL
    } t_cell_op;

    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RESULT
    } t_state;

endpackage

[rtl/core/move_to_front_id_stack_top.sv]
// Move-to-front identifier stack: FSM and a chain of MAX_ENTRIES slot cells.
// The result beat is registered once the command has passed through the APPLY and RESULT states.
// A new command is taken only after the last is compared, shifted and reported; o_out stalls hold it off.
// All cells compare in the accept cycle; the first-match flag ripples down the chain.
// Reset (synchronous, active low) empties the stack and the output register.
`timescale 1ns / 1ps

module move_to_front_id_stack_top #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned IDENT_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mtfids_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mtfids_pkg::t_out_beat o_out_data
);

    localparam int unsigned FW = mtfids_pkg::FIELD_IDENT_W;

    mtfids_pkg::t_state    r_state, n_state;
    mtfids_pkg::t_cell_ctl w_ctl;

    logic [1:0]            r_cmd;
    logic [IDENT_BITS-1:0] r_id;
    logic [IDENT_BITS-1:0] w_in_id, w_cell_id;
    logic [IDENT_BITS+FW-1:0] w_in_ext, w_top_ext;

    logic                  r_matched, n_matched;
    logic                  r_full_drop, n_full_drop;
    logic                  r_out_valid;
    mtfids_pkg::t_out_beat r_out;
    logic                  w_out_free, w_accept;

    logic [IDENT_BITS-1:0] w_entry [MAX_ENTRIES];
    logic                  w_valid [MAX_ENTRIES];
    logic                  w_above [MAX_ENTRIES+1];

    assign w_in_ext  = {{IDENT_BITS{1'b0}}, i_in_data.ident};
    assign w_in_id   = w_in_ext[IDENT_BITS-1:0];
    assign w_top_ext = {{FW{1'b0}}, w_entry[0]};

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cell_id  = (r_state == mtfids_pkg::ST_IDLE) ? w_in_id : r_id;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtfids_pkg::ST_IDLE:   if (i_in_valid) n_state = mtfids_pkg::ST_APPLY;
            mtfids_pkg::ST_APPLY:  n_state = mtfids_pkg::ST_RESULT;
            mtfids_pkg::ST_RESULT: if (w_out_free) n_state = mtfids_pkg::ST_IDLE;
            default:               n_state = mtfids_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine: cell control and result flags
    always_comb begin
        o_in_ready   = 1'b0;
        w_ctl.cmp_en = 1'b0;
        w_ctl.op     = mtfids_pkg::OP_HOLD;
        n_matched    = r_matched;
        n_full_drop  = r_full_drop;
        unique case (r_state)
            mtfids_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                w_ctl.cmp_en = 1'b1;
            end
            mtfids_pkg::ST_APPLY: begin
                n_matched   = 1'b0;
                n_full_drop = 1'b0;
                case (r_cmd)
                    mtfids_pkg::CMD_OPEN: begin
                        // last slot valid means the stack is full
                        if (w_valid[MAX_ENTRIES-1]) begin
                            n_full_drop = 1'b1;
                        end else begin
                            w_ctl.op  = mtfids_pkg::OP_PUSH;
                            n_matched = 1'b1;
                        end
                    end
                    mtfids_pkg::CMD_SWITCH: begin
                        if (w_above[MAX_ENTRIES]) begin
                            w_ctl.op  = mtfids_pkg::OP_SWITCH;
                            n_matched = 1'b1;
                        end
                    end
                    mtfids_pkg::CMD_CLOSE: begin
                        if (w_above[MAX_ENTRIES]) begin
                            w_ctl.op  = mtfids_pkg::OP_PULL;
                            n_matched = 1'b1;
                        end
                    end
                    default: begin
                        w_ctl.op = mtfids_pkg::OP_HOLD;
                    end
                endcase
            end
            mtfids_pkg::ST_RESULT: begin
                w_ctl.op = mtfids_pkg::OP_HOLD;
            end
            default: begin
                w_ctl.op = mtfids_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtfids_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mtfids_pkg::ST_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_data.command;
            r_id  <= w_in_id;
        end
        r_matched   <= n_matched;
        r_full_drop <= n_full_drop;
        if (r_state == mtfids_pkg::ST_RESULT && w_out_free) begin
            r_out.top_ident <= w_valid[0] ? w_top_ext[FW-1:0] : '0;
            r_out.top_valid <= w_valid[0];
            r_out.matched   <= r_matched;
            r_out.full_drop <= r_full_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_above[0] = 1'b0;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        logic [IDENT_BITS-1:0] w_up_entry, w_dn_entry;
        logic                  w_up_valid, w_dn_valid;

        // the slot above the top is the incoming identifier
        if (k == 0) begin : g_first
            assign w_up_entry = r_id;
            assign w_up_valid = 1'b1;
        end else begin : g_mid_up
            assign w_up_entry = w_entry[k-1];
            assign w_up_valid = w_valid[k-1];
        end

        if (k == MAX_ENTRIES - 1) begin : g_last
            assign w_dn_entry = '0;
            assign w_dn_valid = 1'b0;
        end else begin : g_mid_dn
            assign w_dn_entry = w_entry[k+1];
            assign w_dn_valid = w_valid[k+1];
        end

        mtfids_cell #(
            .IDENT_BITS (IDENT_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_id        (w_cell_id),
            .i_up_entry  (w_up_entry),
            .i_up_valid  (w_up_valid),
            .i_dn_entry  (w_dn_entry),
            .i_dn_valid  (w_dn_valid),
            .i_above_hit (w_above[k]),
            .o_entry     (w_entry[k]),
            .o_valid     (w_valid[k]),
            .o_above_hit (w_above[k+1])
        );
    end

endmodule

[rtl/core/mtfids_cell.sv]
// One stack slot: holds an entry, compares it, and shifts with its neighbors.
`timescale 1ns / 1ps

module mtfids_cell #(
    parameter int unsigned IDENT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mtfids_pkg::t_cell_ctl  i_ctl,
    input  logic [IDENT_BITS-1:0]  i_id,
    input  logic [IDENT_BITS-1:0]  i_up_entry,
    input  logic                   i_up_valid,
    input  logic [IDENT_BITS-1:0]  i_dn_entry,
    input  logic                   i_dn_valid,
    input  logic                   i_above_hit,
    output logic [IDENT_BITS-1:0]  o_entry,
    output logic                   o_valid,
    output logic                   o_above_hit
);

    logic [IDENT_BITS-1:0] r_entry, n_entry;
    logic                  r_valid, n_valid;
    logic                  r_hit;

    // hit is only meaningful until the next apply; it is rebuilt on every accept
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_hit <= r_valid && (r_entry == i_id);
        end
    end

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        case (i_ctl.op)
            mtfids_pkg::OP_PUSH: begin
                n_entry = i_up_entry;
                n_valid = i_up_valid;
            end
            mtfids_pkg::OP_SWITCH: begin
                // slots from the top down to the first match slide down one
                if (!i_above_hit) begin
                    n_entry = i_up_entry;
                    n_valid = i_up_valid;
                end
            end
            mtfids_pkg::OP_PULL: begin
                // first match and everything under it slide up one
                if (i_above_hit || r_hit) begin
                    n_entry = i_dn_entry;
                    n_valid = i_dn_valid;
                end
            end
            default: begin
                n_entry = r_entry;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry     = r_entry;
    assign o_valid     = r_valid;
    assign o_above_hit = i_above_hit | r_hit;

endmodule

[test/move_to_front_id_stack_top_tb.sv]
// Self-checking testbench for the move-to-front identifier stack top level.
`timescale 1ns / 1ps

module move_to_front_id_stack_top_tb;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    mtfids_pkg::t_in_beat  i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    mtfids_pkg::t_out_beat o_out_data;

    // shadow copy of the stack, index 0 is the top
    logic [ID_W-1:0]       shadow_ids [DEPTH];
    int unsigned           shadow_cnt = 0;
    mtfids_pkg::t_out_beat top_status_q[$];

    int unsigned n_errors  = 0;
    int unsigned cycle_cnt = 0;
    int unsigned rx_hold   = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    move_to_front_id_stack_top #(
        .MAX_ENTRIES(DEPTH),
        .IDENT_BITS (ID_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one command to the shadow stack and returns the status it reports.
    function automatic mtfids_pkg::t_out_beat mtf_apply(input mtfids_pkg::t_in_beat beat);
        mtfids_pkg::t_out_beat res;
        int unsigned           pos;
        logic [ID_W-1:0]       id;
        id  = beat.ident;
        res = '0;
        pos = shadow_cnt;
        for (int i = int'(shadow_cnt) - 1; i >= 0; i--) begin
            if (shadow_ids[i] == id) pos = unsigned'(i);
        end
        case (beat.command)
            mtfids_pkg::CMD_OPEN: begin
                if (shadow_cnt >= DEPTH) begin
                    res.full_drop = 1'b1;
                end else begin
                    for (int i = int'(shadow_cnt); i > 0; i--) shadow_ids[i] = shadow_ids[i-1];
                    shadow_ids[0] = id;
                    shadow_cnt++;
                    res.matched = 1'b1;
                end
            end
            mtfids_pkg::CMD_SWITCH: begin
                if (pos < shadow_cnt) begin
                    for (int i = int'(pos); i > 0; i--) shadow_ids[i] = shadow_ids[i-1];
                    shadow_ids[0] = id;
                    res.matched = 1'b1;
                end
            end
            mtfids_pkg::CMD_CLOSE: begin
                if (pos < shadow_cnt) begin
                    for (int i = int'(pos); i + 1 < int'(shadow_cnt); i++) begin
                        shadow_ids[i] = shadow_ids[i+1];
                    end
                    shadow_cnt--;
                    res.matched = 1'b1;
                end
            end
            default: ;
        endcase
        res.top_valid = (shadow_cnt > 0);
        res.top_ident = (shadow_cnt > 0) ? shadow_ids[0] : '0;
        return res;
    endfunction

    // Mostly identifiers already on the stack so switch/close hit often.
    function automatic logic [ID_W-1:0] pick_ident();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (shadow_cnt > 0 && r < 60) return shadow_ids[$urandom_range(0, shadow_cnt - 1)];
        if (r < 80) return ID_W'($urandom_range(0, 7));
        return ID_W'($urandom);
    endfunction

    function automatic logic [1:0] pick_cmd(input int unsigned open_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return CMD_UNUSED;
        if (r < 5 + open_pct) return mtfids_pkg::CMD_OPEN;
        return $urandom_range(0, 1) ? mtfids_pkg::CMD_SWITCH : mtfids_pkg::CMD_CLOSE;
    endfunction

    // Offers one command beat and waits for it to be taken.
    task automatic send_cmd(input logic [1:0] cmd, input logic [ID_W-1:0] id);
        mtfids_pkg::t_in_beat beat;
        beat.command = cmd;
        beat.ident   = id;
        while (tx_idle_en && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        top_status_q.push_back(mtf_apply(beat));
    endtask

    task automatic check_status(input mtfids_pkg::t_out_beat got);
        mtfids_pkg::t_out_beat want;
        if (top_status_q.size() == 0) begin
            $error("unexpected result beat: %h", got);
            n_errors++;
        end else begin
            want = top_status_q.pop_front();
            if (got.top_ident !== want.top_ident) begin
                $error("top_ident: expected %h, got %h", want.top_ident, got.top_ident);
                n_errors++;
            end
            if (got.top_valid !== want.top_valid) begin
                $error("top_valid: expected %b, got %b", want.top_valid, got.top_valid);
                n_errors++;
            end
            if (got.matched !== want.matched) begin
                $error("matched: expected %b, got %b", want.matched, got.matched);
                n_errors++;
            end
            if (got.full_drop !== want.full_drop) begin
                $error("full_drop: expected %b, got %b", want.full_drop, got.full_drop);
                n_errors++;
            end
        end
    endtask

    // result side: check each beat, then pick ready for the next cycle
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) check_status(o_out_data);
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !rx_idle_en || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // empty-stack behavior, and a stack that drains back to empty
    task automatic test_empty_stack();
        send_cmd(mtfids_pkg::CMD_SWITCH, 16'h0000);
        send_cmd(mtfids_pkg::CMD_CLOSE, 16'hFFFF);
        send_cmd(CMD_UNUSED, 16'h0000);
        send_cmd(mtfids_pkg::CMD_OPEN, 16'h1234);
        send_cmd(mtfids_pkg::CMD_CLOSE, 16'h1234);
    endtask

    // fill with extreme and duplicate values, then one open that gets dropped
    task automatic test_fill_to_full();
        logic [ID_W-1:0] fill_ids [DEPTH];
        fill_ids = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h0003,
                     16'h5555, 16'h7FFF, 16'h00FF, 16'h0003, 16'hFF00, 16'h0F0F,
                     16'hF0F0, 16'h3C3C, 16'hC3C3, 16'h4242};
        foreach (fill_ids[i]) send_cmd(mtfids_pkg::CMD_OPEN, fill_ids[i]);
        send_cmd(mtfids_pkg::CMD_OPEN, 16'h7777);
    endtask

    // on the full stack: switch top, switch bottom, switch absent, close a duplicate
    task automatic test_reorder_and_remove();
        send_cmd(mtfids_pkg::CMD_SWITCH, 16'h4242);
        send_cmd(mtfids_pkg::CMD_SWITCH, 16'h0000);
        send_cmd(mtfids_pkg::CMD_SWITCH, 16'h1234);
        send_cmd(mtfids_pkg::CMD_CLOSE, 16'h0003);
        send_cmd(CMD_UNUSED, 16'hFFFF);
    endtask

    // open_pct swings per block so the stack keeps filling and draining
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned open_pct;
        open_pct = 40;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (k % 48 == 0) open_pct = $urandom_range(15, 75);
            send_cmd(pick_cmd(open_pct), pick_ident());
        end
    endtask

    // results held off for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        rx_hold = 250;
        test_random_traffic(40);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_fill_to_full();
        test_reorder_and_remove();
        test_random_traffic(700);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(350);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_output_backpressure();
        test_random_traffic(800);
        i_in_valid <= 1'b0;

        while (top_status_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/mtfids_pkg.sv
rtl/core/mtfids_cell.sv
rtl/core/move_to_front_id_stack_top.sv
test/move_to_front_id_stack_top_tb.sv
